>>> rtl/bcd_stopwatch_with_lap_macros.svh
// ----------------------------------------------------------------------------
// bcd_stopwatch_with_lap_macros.svh
// Assertion macros used by the stopwatch top level.
// ----------------------------------------------------------------------------
`ifndef BCD_STOPWATCH_WITH_LAP_MACROS_SVH
`define BCD_STOPWATCH_WITH_LAP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define BSW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stopwatch assertion failed");

// next-cycle implication, disabled during reset
`define BSW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stopwatch assertion failed");

`else

`define BSW_ASSERT_NOW(lbl, ante, cons)
`define BSW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/bcdsw_pkg.sv
// ----------------------------------------------------------------------------
// bcdsw_pkg
// Types and constants for the BCD stopwatch with lap split.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdsw_pkg;

  localparam int unsigned TIME_W  = 20;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned TICKS_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_TENTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_UP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_DOWN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LEFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_SELECT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_IDLE      = 3'd5;

  // reset values of the config registers
  localparam logic [TICKS_W-1:0] RST_TICKS_PER_TENTH = 8'd50;
  localparam logic [LEVEL_W-1:0] RST_BOUND_UP        = 10'h032;
  localparam logic [LEVEL_W-1:0] RST_BOUND_DOWN      = 10'h0C3;
  localparam logic [LEVEL_W-1:0] RST_BOUND_LEFT      = 10'h17C;
  localparam logic [LEVEL_W-1:0] RST_BOUND_SELECT    = 10'h22B;
  localparam logic [LEVEL_W-1:0] RST_BOUND_IDLE      = 10'h316;

  // item opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    BTN_NONE,
    BTN_UP,
    BTN_DOWN,
    BTN_LEFT,
    BTN_SELECT
  } button_t;

  typedef struct packed {
    logic [TICKS_W-1:0] ticks_per_tenth;
    logic [LEVEL_W-1:0] bound_up;
    logic [LEVEL_W-1:0] bound_down;
    logic [LEVEL_W-1:0] bound_left;
    logic [LEVEL_W-1:0] bound_select;
    logic [LEVEL_W-1:0] bound_idle;
  } cfg_t;

  // one item handed from the input register to the core
  typedef struct packed {
    logic    step;
    logic    opcode;
    button_t button;
  } core_cmd_t;

endpackage

`default_nettype wire

>>> rtl/bcd_stopwatch_with_lap.sv
// ----------------------------------------------------------------------------
// bcd_stopwatch_with_lap
// BCD stopwatch (MM:SS.t) with lap split and keypad ADC decoding.
// ----------------------------------------------------------------------------
// Input items carry an opcode (tick or keypad sample) and an ADC level;
// every input item yields exactly one result item holding the time, the
// shown lap start and end, the lap row flag and the run flag after the update.
// Both channels use valid/stall; an item moves when valid is high and stall
// low. The config port writes one register per cycle; the user must write it
// only while the block is idle, which the block does not enforce. An item waits
// in the input register; the state registers, which double as the result
// register, update as it is handed on. Throughput is one item per cycle while
// the receiver does not stall, as the digit carry and prescaler compare are
// combinational. When the receiver stalls, the result is held and the input
// register takes one more item before in_stall rises. Synchronous reset stops
// the watch, zeroes all times, clears the lap row and loads the default config.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_stopwatch_with_lap (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_opcode,
  input  wire logic [bcdsw_pkg::LEVEL_W-1:0]    in_adc_level,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bcdsw_pkg::TIME_W-1:0]          out_time_bcd,
  output logic [bcdsw_pkg::TIME_W-1:0]          out_lap_start_bcd,
  output logic [bcdsw_pkg::TIME_W-1:0]          out_lap_end_bcd,
  output logic                                  out_lap_shown,
  output logic                                  out_running,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bcdsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcdsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcdsw_pkg::*;

`include "bcd_stopwatch_with_lap_macros.svh"

  cfg_t              cfg;
  button_t           button;
  core_cmd_t         cmd;

  logic               in_vld_r;
  logic               opcode_r;
  logic [LEVEL_W-1:0] level_r;
  logic               out_vld_r, out_vld_nxt;
  logic               out_free;
  logic               step;
  logic               in_take;

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      opcode_r <= in_opcode;
      level_r  <= in_adc_level;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  bcdsw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcdsw_keypad u_keypad (
    .level  (level_r),
    .cfg    (cfg),
    .button (button)
  );

  assign cmd.step   = step;
  assign cmd.opcode = opcode_r;
  assign cmd.button = button;

  bcdsw_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .ticks_per_tenth (cfg.ticks_per_tenth),
    .time_bcd        (out_time_bcd),
    .lap_start_bcd   (out_lap_start_bcd),
    .lap_end_bcd     (out_lap_end_bcd),
    .lap_shown       (out_lap_shown),
    .running         (out_running)
  );

  assign out_valid = out_vld_r;

  // state only moves when an item is handed to the result slot
  `BSW_ASSERT_NEXT(a_time_hold_idle, !step, $stable(out_time_bcd))
  // a tick while stopped leaves the time alone
  `BSW_ASSERT_NEXT(a_tick_stopped, step && opcode_r == OP_TICK && !out_running,
                   $stable(out_time_bcd))
  // hidden lap row means both shown times were cleared
  `BSW_ASSERT_NOW(a_lap_hidden_zero, !out_lap_shown,
                  out_lap_start_bcd == '0 && out_lap_end_bcd == '0)
  // digits stay legal BCD, seconds tens below six
  `BSW_ASSERT_NOW(a_time_bcd_legal, 1'b1,
                  out_time_bcd[3:0] <= 4'd9 && out_time_bcd[7:4] <= 4'd9 &&
                  out_time_bcd[11:8] <= 4'd5 && out_time_bcd[15:12] <= 4'd9 &&
                  out_time_bcd[19:16] <= 4'd9)
  // an item moving on always lands in the result slot
  `BSW_ASSERT_NEXT(a_step_valid, step, out_vld_r)

endmodule

`default_nettype wire

>>> rtl/bcdsw_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcdsw_cfg_regs
// Configuration register file: prescaler limit and keypad bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdsw_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bcdsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcdsw_pkg::CFG_DATA_W-1:0] cfg_data,
  output bcdsw_pkg::cfg_t                    cfg
);
  import bcdsw_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_tenth <= RST_TICKS_PER_TENTH;
      cfg_r.bound_up        <= RST_BOUND_UP;
      cfg_r.bound_down      <= RST_BOUND_DOWN;
      cfg_r.bound_left      <= RST_BOUND_LEFT;
      cfg_r.bound_select    <= RST_BOUND_SELECT;
      cfg_r.bound_idle      <= RST_BOUND_IDLE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TICKS_PER_TENTH: cfg_r.ticks_per_tenth <= cfg_data[TICKS_W-1:0];
        REG_BOUND_UP:        cfg_r.bound_up        <= cfg_data[LEVEL_W-1:0];
        REG_BOUND_DOWN:      cfg_r.bound_down      <= cfg_data[LEVEL_W-1:0];
        REG_BOUND_LEFT:      cfg_r.bound_left      <= cfg_data[LEVEL_W-1:0];
        REG_BOUND_SELECT:    cfg_r.bound_select    <= cfg_data[LEVEL_W-1:0];
        REG_BOUND_IDLE:      cfg_r.bound_idle      <= cfg_data[LEVEL_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/bcdsw_keypad.sv
// ----------------------------------------------------------------------------
// bcdsw_keypad
// Maps a keypad ADC level to a button by the configured bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdsw_keypad (
  input  wire logic [bcdsw_pkg::LEVEL_W-1:0] level,
  input  wire bcdsw_pkg::cfg_t              cfg,
  output bcdsw_pkg::button_t                button
);
  import bcdsw_pkg::*;

  // first matching range wins, so bounds out of order leave empty ranges
  always_comb begin
    if (level < cfg.bound_up) begin
      button = BTN_NONE;
    end else if (level < cfg.bound_down) begin
      button = BTN_UP;
    end else if (level < cfg.bound_left) begin
      button = BTN_DOWN;
    end else if (level < cfg.bound_select) begin
      button = BTN_LEFT;
    end else if (level < cfg.bound_idle) begin
      button = BTN_SELECT;
    end else begin
      button = BTN_NONE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bcdsw_core.sv
// ----------------------------------------------------------------------------
// bcdsw_core
// Stopwatch state: prescaler, BCD time, lap capture and lap row.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdsw_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bcdsw_pkg::core_cmd_t          cmd,
  input  wire logic [bcdsw_pkg::TICKS_W-1:0] ticks_per_tenth,
  output logic [bcdsw_pkg::TIME_W-1:0]       time_bcd,
  output logic [bcdsw_pkg::TIME_W-1:0]       lap_start_bcd,
  output logic [bcdsw_pkg::TIME_W-1:0]       lap_end_bcd,
  output logic                               lap_shown,
  output logic                               running
);
  import bcdsw_pkg::*;

  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [TIME_W-1:0]  capture_r, capture_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  end_r, end_nxt;
  logic [TICKS_W-1:0] count_r, count_nxt;
  logic               run_r, run_nxt;
  logic               lap_r, lap_nxt;

  logic [TICKS_W:0]   cnt_inc;
  logic [TICKS_W:0]   cnt_wrap;
  logic               tenth_due;
  logic [TIME_W-1:0]  time_adv;

  // digit carry chain: tenths, sec_lo, sec_hi (mod 6), min_lo, min_hi
  always_comb begin
    logic [3:0] d0, d1, d2, d3, d4;
    d0 = time_r[3:0];
    d1 = time_r[7:4];
    d2 = time_r[11:8];
    d3 = time_r[15:12];
    d4 = time_r[19:16];
    d0 = d0 + 4'd1;
    if (d0 >= 4'd10) begin d0 = 4'd0; d1 = d1 + 4'd1; end
    if (d1 >= 4'd10) begin d1 = 4'd0; d2 = d2 + 4'd1; end
    if (d2 >= 4'd6)  begin d2 = 4'd0; d3 = d3 + 4'd1; end
    if (d3 >= 4'd10) begin d3 = 4'd0; d4 = d4 + 4'd1; end
    if (d4 >= 4'd10) begin d4 = 4'd0; end
    time_adv = {d4, d3, d2, d1, d0};
  end

  assign cnt_inc   = {1'b0, count_r} + {{TICKS_W{1'b0}}, 1'b1};
  assign tenth_due = (cnt_inc >= {1'b0, ticks_per_tenth});
  assign cnt_wrap  = cnt_inc - {1'b0, ticks_per_tenth};

  always_comb begin
    time_nxt    = time_r;
    capture_nxt = capture_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    count_nxt   = count_r;
    run_nxt     = run_r;
    lap_nxt     = lap_r;
    if (cmd.step) begin
      if (cmd.opcode == OP_TICK) begin
        if (run_r) begin
          if (tenth_due) begin
            count_nxt = cnt_wrap[TICKS_W-1:0];
            time_nxt  = time_adv;
          end else begin
            count_nxt = cnt_inc[TICKS_W-1:0];
          end
        end
      end else begin
        case (cmd.button)
          BTN_UP: begin
            start_nxt   = capture_r;
            end_nxt     = time_r;
            capture_nxt = time_r;
            lap_nxt     = 1'b1;
          end
          BTN_DOWN: begin
            capture_nxt = '0;
            start_nxt   = '0;
            end_nxt     = '0;
            lap_nxt     = 1'b0;
          end
          BTN_LEFT: begin
            run_nxt  = 1'b0;
            time_nxt = '0;  // prescaler is kept
          end
          BTN_SELECT: begin
            run_nxt = ~run_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      capture_r <= '0;
      start_r   <= '0;
      end_r     <= '0;
      count_r   <= '0;
      run_r     <= 1'b0;
      lap_r     <= 1'b0;
    end else begin
      time_r    <= time_nxt;
      capture_r <= capture_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      count_r   <= count_nxt;
      run_r     <= run_nxt;
      lap_r     <= lap_nxt;
    end
  end

  assign time_bcd      = time_r;
  assign lap_start_bcd = start_r;
  assign lap_end_bcd   = end_r;
  assign lap_shown     = lap_r;
  assign running       = run_r;

endmodule

`default_nettype wire
